[design/ctok_pkg.sv]
// ctok_pkg: shared types, constants and the normal-mode byte classifier
// for the C subset tokenizer. No dependencies.
package ctok_pkg;

    // Character codes
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    // Token classes
    localparam logic [1:0] CLS_WORD   = 2'd0;
    localparam logic [1:0] CLS_STRING = 2'd1;
    localparam logic [1:0] CLS_OP     = 2'd2;
    localparam logic [1:0] CLS_END    = 2'd3;

    // Input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result queue
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    // Lexer mode, one-hot
    typedef enum logic [7:0] {
        MODE_NORMAL     = 8'b0000_0001,
        MODE_STRING     = 8'b0000_0010,
        MODE_SLASH      = 8'b0000_0100,
        MODE_LINE_CMT   = 8'b0000_1000,
        MODE_BLOCK_CMT  = 8'b0001_0000,
        MODE_BLOCK_STAR = 8'b0010_0000,
        MODE_REL        = 8'b0100_0000,
        MODE_PAIR       = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [1:0] cls;
    } tok_t;

    typedef struct packed {
        tok_t tok;
        logic last;
    } qent_t;

    // Outcome of one byte seen in normal mode
    typedef struct packed {
        logic  emit;
        tok_t  tok;
        mode_t mode;
        logic  word_open;
        logic  clr_bs;
    } norm_t;

    function automatic logic is_word_byte(input logic [7:0] c);
        is_word_byte = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                       (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_single_op(input logic [7:0] c);
        is_single_op = (c == 8'h2B) || (c == 8'h2D) || (c == CH_STAR) || (c == 8'h25) ||
                       (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
                       (c == 8'h5B) || (c == 8'h5D) || (c == 8'h2C) || (c == 8'h3B);
    endfunction

    function automatic norm_t normal_byte(input logic [7:0] c, input logic word_open);
        norm_t r;
        r.emit      = 1'b0;
        r.tok       = '{data: c, start: 1'b1, cls: CLS_OP};
        r.mode      = MODE_NORMAL;
        r.word_open = 1'b0;
        r.clr_bs    = 1'b0;
        if (is_word_byte(c)) begin
            r.emit      = 1'b1;
            r.tok.start = ~word_open;
            r.tok.cls   = CLS_WORD;
            r.word_open = 1'b1;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
            r.word_open = 1'b0;
        end else if (c == CH_QUOTE) begin
            r.emit    = 1'b1;
            r.tok.cls = CLS_STRING;
            r.mode    = MODE_STRING;
            r.clr_bs  = 1'b1;
        end else if (c == CH_SLASH) begin
            r.mode = MODE_SLASH;
        end else if (c == 8'h3C || c == 8'h3E || c == 8'h21 || c == CH_EQUAL) begin
            r.emit = 1'b1;
            r.mode = MODE_REL;
        end else if (c == 8'h7C || c == 8'h26) begin
            r.emit = 1'b1;
            r.mode = MODE_PAIR;
        end else if (is_single_op(c)) begin
            r.emit = 1'b1;
        end else begin
            // unknown byte: dropped, word stays open
            r.word_open = word_open;
        end
        normal_byte = r;
    endfunction

endpackage

[design/c_subset_tokenizer.sv]
// c_subset_tokenizer: top level of the streaming C subset tokenizer.
// Token characters are registered in the result queue and drive m_tvalid from there.
// Throughput: one byte per cycle while results are taken; a byte that yields two
//   results (pending slash flushed) takes two entries of the 4-entry queue.
// Reset (aresetn low, synchronous): normal mode, flags cleared, result queue emptied.
// Depends on ctok_pkg.
module c_subset_tokenizer
    import ctok_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] kind (1 = end of input)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] byte_out
    output logic [2:0]  m_tuser,   // [0] starts_token, [2:1] token_class
    output logic        m_tlast    // run_last
);

    // Lexer state
    mode_t mode_reg, mode_next;
    logic  word_open_reg, word_open_next;
    logic  bs_reg, bs_next;

    // Result queue: up to two words written, one read per cycle
    qent_t             q_reg [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0]  count_reg;

    logic       s_accept, m_accept;
    tok_t       r0, r1;
    logic [1:0] n_res;
    norm_t      nb;

    assign s_accept = s_tvalid & s_tready;
    assign m_accept = m_tvalid & m_tready;

    // Room for a worst-case item (two results) before taking a byte
    assign s_tready = (count_reg <= QCntW'(QDepth - 2));

    // Per-byte lexer step
    always_comb begin
        mode_next      = mode_reg;
        word_open_next = word_open_reg;
        bs_next        = bs_reg;
        r0             = '{data: s_tdata, start: 1'b0, cls: CLS_OP};
        r1             = r0;
        n_res          = 2'd0;
        nb             = normal_byte(s_tdata, word_open_reg);

        if (s_tuser == KIND_END) begin
            mode_next      = MODE_NORMAL;
            word_open_next = 1'b0;
            bs_next        = 1'b0;
            if (mode_reg == MODE_SLASH) begin
                r0    = '{data: CH_SLASH, start: 1'b1, cls: CLS_OP};
                r1    = '{data: CH_HASH, start: 1'b1, cls: CLS_END};
                n_res = 2'd2;
            end else begin
                r0    = '{data: CH_HASH, start: 1'b1, cls: CLS_END};
                n_res = 2'd1;
            end
        end else begin
            unique case (mode_reg)
                MODE_STRING: begin
                    r0    = '{data: s_tdata, start: 1'b0, cls: CLS_STRING};
                    n_res = 2'd1;
                    if (s_tdata == CH_QUOTE && !bs_reg)
                        mode_next = MODE_NORMAL;
                    bs_next = (s_tdata == CH_BACKSLASH);
                end
                MODE_SLASH: begin
                    if (s_tdata == CH_SLASH) begin
                        mode_next = MODE_LINE_CMT;
                    end else if (s_tdata == CH_STAR) begin
                        mode_next = MODE_BLOCK_CMT;
                    end else begin
                        // slash was a division operator; byte runs in normal mode
                        r0             = '{data: CH_SLASH, start: 1'b1, cls: CLS_OP};
                        r1             = nb.tok;
                        n_res          = nb.emit ? 2'd2 : 2'd1;
                        mode_next      = nb.mode;
                        word_open_next = nb.word_open;
                        if (nb.clr_bs)
                            bs_next = 1'b0;
                    end
                end
                MODE_LINE_CMT: begin
                    if (s_tdata == CH_NEWLINE)
                        mode_next = MODE_NORMAL;
                end
                MODE_BLOCK_CMT: begin
                    if (s_tdata == CH_STAR)
                        mode_next = MODE_BLOCK_STAR;
                end
                MODE_BLOCK_STAR: begin
                    // runs of stars keep the close armed
                    if (s_tdata == CH_SLASH)
                        mode_next = MODE_NORMAL;
                    else if (s_tdata != CH_STAR)
                        mode_next = MODE_BLOCK_CMT;
                end
                MODE_REL: begin
                    if (s_tdata == CH_EQUAL) begin
                        r0        = '{data: s_tdata, start: 1'b0, cls: CLS_OP};
                        n_res     = 2'd1;
                        mode_next = MODE_NORMAL;
                    end else begin
                        r0             = nb.tok;
                        n_res          = {1'b0, nb.emit};
                        mode_next      = nb.mode;
                        word_open_next = nb.word_open;
                        if (nb.clr_bs)
                            bs_next = 1'b0;
                    end
                end
                MODE_PAIR: begin
                    // second byte of | or & pair, whatever it is
                    r0        = '{data: s_tdata, start: 1'b0, cls: CLS_OP};
                    n_res     = 2'd1;
                    mode_next = MODE_NORMAL;
                end
                default: begin
                    r0             = nb.tok;
                    n_res          = {1'b0, nb.emit};
                    mode_next      = nb.mode;
                    word_open_next = nb.word_open;
                    if (nb.clr_bs)
                        bs_next = 1'b0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NORMAL;
            word_open_reg <= 1'b0;
            bs_reg        <= 1'b0;
        end else if (s_accept) begin
            mode_reg      <= mode_next;
            word_open_reg <= word_open_next;
            bs_reg        <= bs_next;
        end
    end

    // Queue payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept && n_res != 2'd0) begin
            q_reg[wr_ptr_reg] <= '{tok: r0, last: (n_res == 2'd1)};
            if (n_res == 2'd2)
                q_reg[wr_ptr_reg + QPtrW'(1)] <= '{tok: r1, last: 1'b1};
        end
    end

    // Queue pointers and fill count
    logic [1:0] push_cnt;
    assign push_cnt = s_accept ? n_res : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPtrW'(push_cnt);
            if (m_accept)
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            count_reg <= count_reg + QCntW'(push_cnt) - QCntW'(m_accept);
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = q_reg[rd_ptr_reg].tok.data;
    assign m_tuser  = {q_reg[rd_ptr_reg].tok.cls, q_reg[rd_ptr_reg].tok.start};
    assign m_tlast  = q_reg[rd_ptr_reg].last;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCntW'(QDepth))
        else $error("result queue overfilled");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == KIND_END) |=>
            (mode_reg == MODE_NORMAL && !word_open_reg && !bs_reg))
        else $error("end of input did not return lexer to normal");

    a_pair_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && n_res == 2'd2 && !m_accept) |=>
            (count_reg == $past(count_reg) + QCntW'(2)))
        else $error("two-result item not queued in full");

    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == KIND_END && count_reg == '0) |=>
            (m_tvalid && (m_tdata == CH_HASH || m_tdata == CH_SLASH)))
        else $error("end marker missing after end of input");

endmodule
